@@ hdl/jkr_pkg.sv @@
// ----------------------------------------------------------------------------
// jkr_pkg
// Shared types and constants of the JKISS ranged random block.
// ----------------------------------------------------------------------------
package jkr_pkg;

  localparam int WordW  = 32;
  localparam int CarryW = 30;
  localparam int AddrW  = 4;

  localparam logic [WordW-1:0] LcgMul = 32'd314527869;
  localparam logic [WordW-1:0] LcgAdd = 32'd1234567;
  localparam logic [WordW-1:0] MwcMul = 32'd4294584393;

  localparam logic [WordW-1:0]  RstSeedLcg   = 32'd123456789;
  localparam logic [WordW-1:0]  RstSeedXs    = 32'd987654321;
  localparam logic [WordW-1:0]  RstSeedMwc   = 32'd43219876;
  localparam logic [CarryW-1:0] RstSeedCarry = 30'd6543217;

  typedef enum logic [1:0] {
    RegSeedLcg   = 2'd0,
    RegSeedXs    = 2'd1,
    RegSeedMwc   = 2'd2,
    RegSeedCarry = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [WordW-1:0]  lcg;
    logic [WordW-1:0]  xs;
    logic [WordW-1:0]  mwc;
    logic [CarryW-1:0] carry;
  } seed_t;

  // controller -> datapath
  typedef struct packed {
    logic load_bound;
    logic step;
    logic sum;
    logic scale;
  } cmd_t;

endpackage

@@ hdl/jkr_if.sv @@
// ----------------------------------------------------------------------------
// jkr_if
// Valid/ready stream interfaces for the bound and value channels.
// ----------------------------------------------------------------------------
interface jkr_bound_if;
  logic                       valid;
  logic                       ready;
  logic [jkr_pkg::WordW-1:0]  bound;

  modport source (output valid, output bound, input ready);
  modport sink   (input valid, input bound, output ready);
endinterface

interface jkr_value_if;
  logic                       valid;
  logic                       ready;
  logic [jkr_pkg::WordW-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

@@ hdl/jkr_regs.sv @@
// ----------------------------------------------------------------------------
// jkr_regs
// APB seed registers; a write reloads the generator state from all seeds.
// ----------------------------------------------------------------------------
module jkr_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jkr_pkg::AddrW-1:0]   paddr,
  input  logic [jkr_pkg::WordW-1:0]   pwdata,
  output logic [jkr_pkg::WordW-1:0]   prdata,
  output logic                        pready,
  output jkr_pkg::seed_t              seed_d_o,
  output logic                        load_o
);

  jkr_pkg::seed_t   seed_q, seed_d;
  jkr_pkg::reg_idx_e idx;
  logic             wr;

  assign pready = 1'b1;
  assign idx    = jkr_pkg::reg_idx_e'(paddr[3:2]);
  assign wr     = psel & penable & pwrite;

  always_comb begin
    seed_d = seed_q;
    if (wr) begin
      unique case (idx)
        jkr_pkg::RegSeedLcg:   seed_d.lcg   = pwdata;
        jkr_pkg::RegSeedXs:    seed_d.xs    = pwdata;
        jkr_pkg::RegSeedMwc:   seed_d.mwc   = pwdata;
        jkr_pkg::RegSeedCarry: seed_d.carry = pwdata[jkr_pkg::CarryW-1:0];
        default:               seed_d       = seed_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      jkr_pkg::RegSeedLcg:   prdata = seed_q.lcg;
      jkr_pkg::RegSeedXs:    prdata = seed_q.xs;
      jkr_pkg::RegSeedMwc:   prdata = seed_q.mwc;
      jkr_pkg::RegSeedCarry: prdata = {{(jkr_pkg::WordW-jkr_pkg::CarryW){1'b0}},
                                       seed_q.carry};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q.lcg   <= jkr_pkg::RstSeedLcg;
      seed_q.xs    <= jkr_pkg::RstSeedXs;
      seed_q.mwc   <= jkr_pkg::RstSeedMwc;
      seed_q.carry <= jkr_pkg::RstSeedCarry;
    end else begin
      seed_q <= seed_d;
    end
  end

  assign seed_d_o = seed_d;
  assign load_o   = wr;

endmodule

@@ hdl/jkr_ctrl.sv @@
// ----------------------------------------------------------------------------
// jkr_ctrl
// Sequencer: accept bound, step generators, sum, scale into output register.
// ----------------------------------------------------------------------------
module jkr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_ready_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output jkr_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StStep = 4'b0010,
    StSum  = 4'b0100,
    StMul  = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic          out_valid_q, out_valid_d;
  jkr_pkg::cmd_t cmd;

  always_comb begin
    state_d    = state_q;
    cmd        = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.load_bound = 1'b1;
          state_d        = StStep;
        end
      end
      StStep: begin
        cmd.step = 1'b1;
        state_d  = StSum;
      end
      StSum: begin
        cmd.sum = 1'b1;
        state_d = StMul;
      end
      StMul: begin
        // wait for a free output register
        if (!out_valid_q || out_ready_i) begin
          cmd.scale = 1'b1;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    priority if (cmd.scale) out_valid_d = 1'b1;
    else if (out_ready_i)   out_valid_d = 1'b0;
    else                    out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  a_accept_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> cmd.step)
    else $error("accepted beat not followed by generator step");

  a_step_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |=> cmd.sum)
    else $error("generator step not followed by sum");

  a_scale_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scale |=> (out_valid_q && in_ready_o))
    else $error("scaled result not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.scale && out_valid_q) |-> out_ready_i)
    else $error("output register overwritten before taken");

endmodule

@@ hdl/jkr_dp.sv @@
// ----------------------------------------------------------------------------
// jkr_dp
// Generator state (LCG, xorshift, MWC), combining sum and bound scaling.
// ----------------------------------------------------------------------------
module jkr_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  jkr_pkg::cmd_t              cmd_i,
  input  jkr_pkg::seed_t             seed_i,
  input  logic                       load_i,
  input  logic [jkr_pkg::WordW-1:0]  bound_i,
  output logic [jkr_pkg::WordW-1:0]  value_o
);

  localparam int W = jkr_pkg::WordW;

  logic [W-1:0]   x_q, x_d, y_q, y_d, z_q, z_d, c_q, c_d;
  logic [W-1:0]   bound_q, sum_q, value_q;
  logic [W-1:0]   y1, y2;
  logic [2*W-1:0] mwc_t, scale_p;

  // xorshift 5 / 7 / 22
  assign y1 = y_q ^ (y_q << 5);
  assign y2 = y1 ^ (y1 >> 7);

  assign mwc_t   = (2*W)'(z_q) * (2*W)'(jkr_pkg::MwcMul) + (2*W)'(c_q);
  assign scale_p = (2*W)'(sum_q) * (2*W)'(bound_q);

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    c_d = c_q;
    priority if (load_i) begin
      x_d = seed_i.lcg;
      y_d = seed_i.xs;
      z_d = seed_i.mwc;
      c_d = W'(seed_i.carry);
    end else if (cmd_i.step) begin
      x_d = W'(x_q * jkr_pkg::LcgMul) + jkr_pkg::LcgAdd;
      y_d = y2 ^ (y2 << 22);
      z_d = mwc_t[W-1:0];
      c_d = mwc_t[2*W-1:W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= jkr_pkg::RstSeedLcg;
      y_q <= jkr_pkg::RstSeedXs;
      z_q <= jkr_pkg::RstSeedMwc;
      c_q <= W'(jkr_pkg::RstSeedCarry);
    end else begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      c_q <= c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_bound) bound_q <= bound_i;
    if (cmd_i.sum)        sum_q   <= x_q + y_q + z_q;
    if (cmd_i.scale)      value_q <= scale_p[2*W-1:W];
  end

  assign value_o = value_q;

  a_xs_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !load_i && (y_q != '0)) |=> (y_q != '0))
    else $error("xorshift word collapsed to zero");

  a_load_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> ((x_q == $past(seed_i.lcg)) && (c_q == W'($past(seed_i.carry)))))
    else $error("seed reload did not reach generator state");

endmodule

@@ hdl/jkiss_ranged_random.sv @@
// ----------------------------------------------------------------------------
// jkiss_ranged_random
// JKISS random generator returning floor(rand32 * bound / 2^32) per request.
// ----------------------------------------------------------------------------
// Usage:
//   bound_i : request channel; each beat carries an exclusive upper bound.
//   value_o : result channel; one beat per request, value in 0 .. bound-1
//             (zero when bound is zero).
//   APB     : four seed registers at byte 0, 4, 8, 12 (LCG, xorshift,
//             MWC word, MWC carry). Any write reloads all generator state
//             from the seeds. Write only while no request is in flight.
// Timing:
//   A request is taken in the idle state; the result is valid once the
//   step, sum and scale states have passed. The sequencer walks idle, step,
//   sum and scale in turn and takes no new request before scaling the last.
//   The scale step holds while the output register is full and the
//   receiver stalls; a request can be taken while a result waits.
// Reset:
//   Seeds return to their defaults and the generator state equals them;
//   no result is pending.
// ----------------------------------------------------------------------------
module jkiss_ranged_random (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  jkr_bound_if.sink                   bound_i,
  jkr_value_if.source                 value_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jkr_pkg::AddrW-1:0]   paddr,
  input  logic [jkr_pkg::WordW-1:0]   pwdata,
  output logic [jkr_pkg::WordW-1:0]   prdata,
  output logic                        pready
);

  jkr_pkg::cmd_t  cmd;
  jkr_pkg::seed_t seed_d;
  logic           load;

  jkr_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .seed_d_o (seed_d),
    .load_o   (load)
  );

  jkr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bound_i.valid),
    .out_ready_i (value_o.ready),
    .in_ready_o  (bound_i.ready),
    .out_valid_o (value_o.valid),
    .cmd_o       (cmd)
  );

  jkr_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .seed_i  (seed_d),
    .load_i  (load),
    .bound_i (bound_i.bound),
    .value_o (value_o.value)
  );

endmodule

@@ tb/sv/jkiss_ranged_random_tb.sv @@
// ----------------------------------------------------------------------------
// jkiss_ranged_random_tb
// Self-checking bench for the JKISS ranged random block. A local copy of the
// three generators predicts each scaled value. Values are checked in order
// against the value channel while both sides idle at random. Seed registers
// are written over APB between traffic phases and read back.
// ----------------------------------------------------------------------------
module jkiss_ranged_random_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WordW  = jkr_pkg::WordW;
  localparam int CarryW = jkr_pkg::CarryW;
  localparam int AddrW  = jkr_pkg::AddrW;

  localparam int StallLimit = 4000;
  localparam logic [WordW-1:0] CarryHigh = 32'd698769068;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [WordW-1:0] pwdata;
  logic [WordW-1:0] prdata;
  logic             pready;

  jkr_bound_if bnd_if ();
  jkr_value_if val_if ();

  jkiss_ranged_random u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .bound_i (bnd_if),
    .value_o (val_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor copy of the seed registers and generator state
  logic [WordW-1:0] seed_regs [4];
  logic [WordW-1:0] lcg_w, xs_w, mwc_w, carry_w;

  logic [WordW-1:0] pending_values [$];
  int errors      = 0;
  int idle_cycles = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  function automatic void reload_generators();
    lcg_w   = seed_regs[jkr_pkg::RegSeedLcg];
    xs_w    = seed_regs[jkr_pkg::RegSeedXs];
    mwc_w   = seed_regs[jkr_pkg::RegSeedMwc];
    carry_w = seed_regs[jkr_pkg::RegSeedCarry];
  endfunction

  function automatic void store_seed(jkr_pkg::reg_idx_e idx, logic [WordW-1:0] data);
    if (idx == jkr_pkg::RegSeedCarry) begin
      seed_regs[idx] = {{(WordW-CarryW){1'b0}}, data[CarryW-1:0]};
    end else begin
      seed_regs[idx] = data;
    end
    reload_generators();
  endfunction

  // advance all three generators and scale the combined word by the bound
  function automatic logic [WordW-1:0] draw_ranged(logic [WordW-1:0] bound);
    logic [WordW-1:0]   y;
    logic [2*WordW-1:0] t;
    logic [WordW-1:0]   sum;
    logic [2*WordW-1:0] prod;
    lcg_w = lcg_w * jkr_pkg::LcgMul + jkr_pkg::LcgAdd;
    y = xs_w;
    y = y ^ (y << 5);
    y = y ^ (y >> 7);
    y = y ^ (y << 22);
    xs_w = y;
    t = {{WordW{1'b0}}, jkr_pkg::MwcMul} * {{WordW{1'b0}}, mwc_w}
        + {{WordW{1'b0}}, carry_w};
    carry_w = t[2*WordW-1:WordW];
    mwc_w   = t[WordW-1:0];
    sum  = lcg_w + xs_w + mwc_w;
    prod = {{WordW{1'b0}}, sum} * {{WordW{1'b0}}, bound};
    return prod[2*WordW-1:WordW];
  endfunction

  // --------------------------------------------------------------------------
  // drivers; every task is entered and left just after a falling edge

  task automatic send_bound(input logic [WordW-1:0] bound);
    while ($urandom_range(99) < src_idle_pct) begin
      bnd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    bnd_if.valid <= 1'b1;
    bnd_if.bound <= bound;
    do @(posedge clk_i); while (!bnd_if.ready);
    pending_values.push_back(draw_ranged(bound));
    @(negedge clk_i);
  endtask

  task automatic apb_write(input jkr_pkg::reg_idx_e idx, input logic [WordW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx) << 2;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    store_seed(idx, data);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apb_read_check(input jkr_pkg::reg_idx_e idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrW'(idx) << 2;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== seed_regs[idx]) begin
      $display("%0t: seed %s readback mismatch: expected %h, actual %h",
               $time, idx.name(), seed_regs[idx], prdata);
      errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // stop sending and let the block drain before touching the seeds
  task automatic settle();
    bnd_if.valid <= 1'b0;
    while (pending_values.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_all_seeds(input logic [WordW-1:0] lcg, input logic [WordW-1:0] xs,
                                 input logic [WordW-1:0] mwc, input logic [WordW-1:0] carry);
    apb_write(jkr_pkg::RegSeedLcg, lcg);
    apb_write(jkr_pkg::RegSeedXs, xs);
    apb_write(jkr_pkg::RegSeedMwc, mwc);
    apb_write(jkr_pkg::RegSeedCarry, carry);
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    val_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // value checker
  always @(posedge clk_i) begin
    logic [WordW-1:0] want;
    if (rst_ni && val_if.valid && val_if.ready) begin
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected value beat: expected none, actual %h",
                 $time, val_if.value);
        errors++;
      end else begin
        want = pending_values.pop_front();
        if (val_if.value !== want) begin
          $display("%0t: value mismatch: expected %h, actual %h",
                   $time, want, val_if.value);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((bnd_if.valid && bnd_if.ready) || (val_if.valid && val_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests

  task automatic test_reset_defaults();
    apb_read_check(jkr_pkg::RegSeedLcg);
    apb_read_check(jkr_pkg::RegSeedXs);
    apb_read_check(jkr_pkg::RegSeedMwc);
    apb_read_check(jkr_pkg::RegSeedCarry);
  endtask

  task automatic test_bound_extremes();
    send_bound(32'h0000_0000);
    send_bound(32'h0000_0001);
    send_bound(32'h0000_0002);
    send_bound(32'hFFFF_FFFF);
    send_bound(32'h8000_0000);
    send_bound(32'h7FFF_FFFF);
    send_bound(32'hAAAA_AAAA);
    send_bound(32'h5555_5555);
    settle();
  endtask

  // xorshift word stuck at zero
  task automatic test_zero_xorshift();
    apb_write(jkr_pkg::RegSeedXs, 32'h0);
    apb_read_check(jkr_pkg::RegSeedXs);
    send_bound(32'hFFFF_FFFF);
    send_bound(32'h0);
    send_bound(32'hFFFF_FFFF);
    settle();
  endtask

  // carry seeds outside the legal range, and bits above the 30-bit field
  task automatic test_carry_out_of_range();
    apb_write(jkr_pkg::RegSeedCarry, 32'h0);
    send_bound(32'hFFFF_FFFF);
    send_bound(32'hFFFF_FFFF);
    settle();
    apb_write(jkr_pkg::RegSeedCarry, 32'hFFFF_FFFF);
    apb_read_check(jkr_pkg::RegSeedCarry);
    send_bound(32'hFFFF_FFFF);
    send_bound(32'h1234_5678);
    settle();
  endtask

  task automatic test_seed_extremes();
    write_all_seeds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, CarryHigh);
    apb_read_check(jkr_pkg::RegSeedCarry);
    send_bound(32'hFFFF_FFFF);
    send_bound(32'hFFFF_FFFF);
    send_bound(32'h0000_0003);
    settle();
    write_all_seeds(32'h0, 32'h1, 32'h0, 32'h1);
    send_bound(32'hFFFF_FFFF);
    send_bound(32'hFFFF_FFFF);
    send_bound(32'h0001_0000);
    settle();
  endtask

  function automatic logic [WordW-1:0] pick_seed(jkr_pkg::reg_idx_e idx);
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return (idx == jkr_pkg::RegSeedCarry) ? CarryHigh : 32'h1;
      3:       return (idx == jkr_pkg::RegSeedCarry) ? 32'h1 : 32'h8000_0000;
      default: return (idx == jkr_pkg::RegSeedCarry) ? $urandom_range(1, CarryHigh)
                                                     : $urandom();
    endcase
  endfunction

  function automatic logic [WordW-1:0] pick_bound();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return $urandom_range(1, 16);
      4:       return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                     input int n_items);
    int sent;
    int burst;
    int sel;
    sent = 0;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    while (sent < n_items) begin
      // reseed some of the registers; unwritten ones still reload the state
      sel = $urandom_range(1, 15);
      for (int r = 0; r < 4; r++) begin
        if (sel[r]) apb_write(jkr_pkg::reg_idx_e'(r), pick_seed(jkr_pkg::reg_idx_e'(r)));
      end
      if ($urandom_range(0, 3) == 0) begin
        apb_read_check(jkr_pkg::reg_idx_e'($urandom_range(0, 3)));
      end
      burst = $urandom_range(20, 80);
      for (int i = 0; i < burst && sent < n_items; i++) begin
        send_bound(pick_bound());
        sent++;
      end
      settle();
    end
  endtask

  initial begin
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    bnd_if.valid <= 1'b0;
    bnd_if.bound <= '0;
    seed_regs[jkr_pkg::RegSeedLcg]   = jkr_pkg::RstSeedLcg;
    seed_regs[jkr_pkg::RegSeedXs]    = jkr_pkg::RstSeedXs;
    seed_regs[jkr_pkg::RegSeedMwc]   = jkr_pkg::RstSeedMwc;
    seed_regs[jkr_pkg::RegSeedCarry] = {{(WordW-CarryW){1'b0}}, jkr_pkg::RstSeedCarry};
    reload_generators();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_bound_extremes();
    test_zero_xorshift();
    test_carry_out_of_range();
    test_seed_extremes();
    test_random_traffic(17, 52, 476);
    test_random_traffic(52, 17, 476);
    test_random_traffic(0, 0, 476);

    settle();
    repeat (8) @(negedge clk_i);
    if (errors == 0 && pending_values.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
